// ===== hw/rtl/sphere_triangle_subdivider_defines.svh =====
// Assertion macros shared by the sphere triangle subdivider checker.
// Needs clk and rst_n visible at the place of use.
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_DEFINES_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_DEFINES_SVH

// Condition that holds at every clock edge out of reset
`define STS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle implies a consequence in the same cycle
`define STS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sts_pkg.sv =====
// Package for the sphere triangle subdivider: defaults, state codes, vector type.
// No dependencies.
`timescale 1ns / 1ps

package sts_pkg;

    localparam int INDEX_BITS_DEF      = 16;
    localparam int COORD_FRAC_BITS_DEF = 14;
    localparam int COORD_W             = 16;
    localparam int CFG_W               = 16;
    localparam int START_COUNT_RESET   = 12;

    // Normalised midpoint, one Q1.F coordinate per axis, x in the low bits
    typedef struct packed {
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } sts_vec_t;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_RUN  = 3'b010,
        T_EMIT = 3'b100
    } sts_top_state_t;

    typedef enum logic [5:0] {
        N_IDLE = 6'b000001,
        N_SQR  = 6'b000010,
        N_SUM  = 6'b000100,
        N_LOAD = 6'b001000,
        N_ITER = 6'b010000,
        N_SIGN = 6'b100000
    } sts_norm_state_t;

endpackage

// ===== hw/rtl/sphere_triangle_subdivider.sv =====
// Top level of the sphere triangle subdivider: handshakes, vertex counter, child triangles.
// Depends on sts_pkg and sts_norm.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata: corners a,b,c (x,y,z) then index_a,b,c
//  m_*       out  m_tvalid/m_tready   m_tdata, m_tuser (vertex_valid), m_tlast
//  cfg_*     in   cfg_we              cfg_wdata: start_vertex_count
//
// The first result beat of a triangle waits on the normaliser, which produces one result bit
// a cycle for each of nine components.
// The four result beats then follow, each one held while m_tready stalls it.
// s_tready is high only while the block is idle. Reset loads the vertex counter with 12;
// a configuration write reloads it.
`timescale 1ns / 1ps

module sphere_triangle_subdivider #(
    parameter int INDEX_BITS      = sts_pkg::INDEX_BITS_DEF,
    parameter int COORD_FRAC_BITS = sts_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // corner_a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, index_a, index_b, index_c
    input  logic [((144 + 3 * INDEX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // new_x, new_y, new_z, tri_first, tri_second, tri_third, overflow
    output logic [((49 + 3 * INDEX_BITS + 7) / 8) * 8 - 1:0]  m_tdata,
    // vertex_valid
    output logic [0:0]                                m_tuser,
    output logic                                      m_tlast,
    input  logic                                      cfg_we,
    input  logic [sts_pkg::CFG_W-1:0]                 cfg_wdata
);

    localparam int CW     = sts_pkg::COORD_W;
    localparam int IDX0   = 9 * CW;
    localparam int TRI0   = 3 * CW;
    localparam int OVF_B  = 3 * CW + 3 * INDEX_BITS;
    localparam int CNT_W  = (INDEX_BITS + 1 > sts_pkg::CFG_W + 1) ? INDEX_BITS + 1
                                                                 : sts_pkg::CFG_W + 1;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(1) << INDEX_BITS;

    sts_pkg::sts_top_state_t state_reg;

    logic signed [CW-1:0]    corner_reg [3][3];
    logic [INDEX_BITS-1:0]   idx_reg [3];
    logic [INDEX_BITS-1:0]   nidx_reg [3];
    logic                    ovf_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [1:0]              edge_reg;
    logic                    launch_reg;
    logic [1:0]              beat_reg;
    sts_pkg::sts_vec_t       mid_reg [3];

    logic                    in_beat;
    logic                    out_beat;
    logic                    norm_done;
    sts_pkg::sts_vec_t       norm_res;
    logic signed [16:0]      esum [3];
    logic [CNT_W-1:0]        cnt_walk [4];
    logic [INDEX_BITS-1:0]   nidx_next [3];
    logic                    ovf_next;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;
    assign s_tready = (state_reg == sts_pkg::T_IDLE);
    assign m_tvalid = (state_reg == sts_pkg::T_EMIT);

    // Corner sum of the current edge: a-b, b-c, then a-c
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            esum[i] = 17'(corner_reg[(edge_reg == 2'd1) ? 1 : 0][i])
                    + 17'(corner_reg[(edge_reg == 2'd0) ? 1 : 2][i]);
        end
    end

    // Hand out three indices from the counter, saturating at the limit
    always_comb
    begin
        cnt_walk[0] = cnt_reg;
        ovf_next    = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            nidx_next[k] = cnt_walk[k][INDEX_BITS-1:0];
            if (cnt_walk[k] >= LIMIT)
            begin
                ovf_next      = 1'b1;
                cnt_walk[k+1] = LIMIT;
            end
            else
            begin
                cnt_walk[k+1] = cnt_walk[k] + CNT_W'(1);
            end
        end
    end

    sts_norm #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (launch_reg),
        .sum_x  (esum[0]),
        .sum_y  (esum[1]),
        .sum_z  (esum[2]),
        .done   (norm_done),
        .result (norm_res)
    );

    // Sequencer and vertex counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sts_pkg::T_IDLE;
            cnt_reg    <= CNT_W'(sts_pkg::START_COUNT_RESET);
            edge_reg   <= 2'd0;
            launch_reg <= 1'b0;
            beat_reg   <= 2'd0;
        end
        else
        begin
            launch_reg <= 1'b0;
            if (cfg_we)
            begin
                cnt_reg <= CNT_W'(cfg_wdata);
            end
            unique case (state_reg)
                sts_pkg::T_IDLE:
                begin
                    if (in_beat)
                    begin
                        cnt_reg    <= cnt_walk[3];
                        edge_reg   <= 2'd0;
                        launch_reg <= 1'b1;
                        state_reg  <= sts_pkg::T_RUN;
                    end
                end
                sts_pkg::T_RUN:
                begin
                    if (norm_done)
                    begin
                        if (edge_reg == 2'd2)
                        begin
                            beat_reg  <= 2'd0;
                            state_reg <= sts_pkg::T_EMIT;
                        end
                        else
                        begin
                            edge_reg   <= edge_reg + 2'd1;
                            launch_reg <= 1'b1;
                        end
                    end
                end
                sts_pkg::T_EMIT:
                begin
                    if (out_beat)
                    begin
                        beat_reg <= beat_reg + 2'd1;
                        if (beat_reg == 2'd3)
                        begin
                            state_reg <= sts_pkg::T_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= sts_pkg::T_IDLE;
                end
            endcase
        end
    end

    // Capture the triangle and the normalised midpoints
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    corner_reg[c][i] <= s_tdata[(3 * c + i) * CW +: CW];
                end
                idx_reg[c]  <= s_tdata[IDX0 + c * INDEX_BITS +: INDEX_BITS];
                nidx_reg[c] <= nidx_next[c];
            end
            ovf_reg <= ovf_next;
        end
        if (norm_done)
        begin
            mid_reg[edge_reg] <= norm_res;
        end
    end

    // Build the current child triangle beat
    always_comb
    begin
        m_tdata    = '0;
        m_tuser[0] = (beat_reg != 2'd3);
        m_tlast    = (beat_reg == 2'd3);
        case (beat_reg)
            2'd0:
            begin
                m_tdata[0 +: TRI0] = mid_reg[0];
                m_tdata[TRI0 +: INDEX_BITS]                  = nidx_reg[0];
                m_tdata[TRI0 + INDEX_BITS +: INDEX_BITS]     = nidx_reg[1];
                m_tdata[TRI0 + 2 * INDEX_BITS +: INDEX_BITS] = nidx_reg[2];
            end
            2'd1:
            begin
                m_tdata[0 +: TRI0] = mid_reg[1];
                m_tdata[TRI0 +: INDEX_BITS]                  = idx_reg[0];
                m_tdata[TRI0 + INDEX_BITS +: INDEX_BITS]     = nidx_reg[0];
                m_tdata[TRI0 + 2 * INDEX_BITS +: INDEX_BITS] = nidx_reg[2];
            end
            2'd2:
            begin
                m_tdata[0 +: TRI0] = mid_reg[2];
                m_tdata[TRI0 +: INDEX_BITS]                  = nidx_reg[0];
                m_tdata[TRI0 + INDEX_BITS +: INDEX_BITS]     = idx_reg[1];
                m_tdata[TRI0 + 2 * INDEX_BITS +: INDEX_BITS] = nidx_reg[1];
            end
            default:
            begin
                m_tdata[TRI0 +: INDEX_BITS]                  = nidx_reg[1];
                m_tdata[TRI0 + INDEX_BITS +: INDEX_BITS]     = idx_reg[2];
                m_tdata[TRI0 + 2 * INDEX_BITS +: INDEX_BITS] = nidx_reg[2];
            end
        endcase
        m_tdata[OVF_B] = ovf_reg;
    end

endmodule

// ===== hw/rtl/sts_norm.sv =====
// Midpoint normaliser: scales a corner sum to unit length, one result bit a cycle.
// Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_norm #(
    parameter int FRAC_BITS = sts_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [16:0]    sum_x,
    input  logic signed [16:0]    sum_y,
    input  logic signed [16:0]    sum_z,
    output logic                  done,
    output sts_pkg::sts_vec_t     result
);

    localparam int MAG_W  = 17;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SS_W   = SQ_W + 2;
    localparam int ACC_W  = 2 * FRAC_BITS + 40;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int BIT_W  = $clog2(FRAC_BITS + 1);
    localparam int OUT_W  = sts_pkg::COORD_W;

    sts_pkg::sts_norm_state_t state_reg;

    logic signed [16:0]       sv_reg [3];
    logic [SQ_W-1:0]          sq_reg [3];
    logic [SS_W-1:0]          ssum_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  tap_reg;
    logic signed [ACC_W-1:0]  sft_reg;
    logic signed [ACC_W-1:0]  lim_reg;
    logic [Q_W-1:0]           q_reg;
    logic [BIT_W-1:0]         bit_reg;
    logic [1:0]               comp_reg;
    logic [OUT_W-1:0]         res_reg [3];
    logic                     done_reg;

    logic signed [16:0]       sv_sel;
    logic [MAG_W-1:0]         mag;
    logic [SQ_W-1:0]          prod;
    logic signed [ACC_W-1:0]  ss_ext;
    logic signed [ACC_W-1:0]  sq_ext;
    logic signed [ACC_W-1:0]  cand;
    logic                     fits;
    logic [ACC_W-1:0]         q_ext;
    logic [ACC_W-1:0]         q_neg;

    // Shared squarer on the selected component magnitude
    always_comb
    begin
        sv_sel = sv_reg[comp_reg];
        mag    = sv_sel[16] ? MAG_W'(-sv_sel) : MAG_W'(sv_sel);
        prod   = mag * mag;
    end

    // Trial step: candidate (2q-1)^2 * S against |s|^2 * 2^(2F+2)
    always_comb
    begin
        ss_ext = {{(ACC_W - SS_W){1'b0}}, ssum_reg};
        sq_ext = {{(ACC_W - SQ_W){1'b0}}, sq_reg[comp_reg]};
        cand   = acc_reg + tap_reg + sft_reg;
        fits   = (cand <= lim_reg);
        q_ext  = {{(ACC_W - Q_W){1'b0}}, q_reg};
        q_neg  = -q_ext;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sts_pkg::N_IDLE;
            comp_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                sts_pkg::N_IDLE:
                begin
                    comp_reg <= 2'd0;
                    if (start)
                    begin
                        state_reg <= sts_pkg::N_SQR;
                    end
                end
                sts_pkg::N_SQR:
                begin
                    if (comp_reg == 2'd2)
                    begin
                        comp_reg  <= 2'd0;
                        state_reg <= sts_pkg::N_SUM;
                    end
                    else
                    begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                sts_pkg::N_SUM:
                begin
                    state_reg <= sts_pkg::N_LOAD;
                end
                sts_pkg::N_LOAD:
                begin
                    state_reg <= (ssum_reg == '0) ? sts_pkg::N_SIGN : sts_pkg::N_ITER;
                end
                sts_pkg::N_ITER:
                begin
                    if (bit_reg == '0)
                    begin
                        state_reg <= sts_pkg::N_SIGN;
                    end
                end
                sts_pkg::N_SIGN:
                begin
                    if (comp_reg == 2'd2)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= sts_pkg::N_IDLE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= sts_pkg::N_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= sts_pkg::N_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sts_pkg::N_IDLE:
            begin
                if (start)
                begin
                    sv_reg[0] <= sum_x;
                    sv_reg[1] <= sum_y;
                    sv_reg[2] <= sum_z;
                end
            end
            sts_pkg::N_SQR:
            begin
                sq_reg[comp_reg] <= prod;
            end
            sts_pkg::N_SUM:
            begin
                ssum_reg <= SS_W'(sq_reg[0]) + SS_W'(sq_reg[1]) + SS_W'(sq_reg[2]);
            end
            sts_pkg::N_LOAD:
            begin
                acc_reg <= ss_ext;
                tap_reg <= -(ss_ext <<< (FRAC_BITS + 2));
                sft_reg <= ss_ext <<< (2 * FRAC_BITS + 2);
                lim_reg <= sq_ext <<< (2 * FRAC_BITS + 2);
                q_reg   <= '0;
                bit_reg <= BIT_W'(FRAC_BITS);
            end
            sts_pkg::N_ITER:
            begin
                // Commit the bit when the candidate still fits, then narrow the step
                if (fits)
                begin
                    acc_reg <= cand;
                    tap_reg <= (tap_reg + (sft_reg <<< 1)) >>> 1;
                end
                else
                begin
                    tap_reg <= tap_reg >>> 1;
                end
                sft_reg <= sft_reg >>> 2;
                q_reg   <= {q_reg[Q_W-2:0], fits};
                bit_reg <= bit_reg - BIT_W'(1);
            end
            sts_pkg::N_SIGN:
            begin
                res_reg[comp_reg] <= sv_sel[16] ? q_neg[OUT_W-1:0] : q_ext[OUT_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign done     = done_reg;
    assign result.x = res_reg[0];
    assign result.y = res_reg[1];
    assign result.z = res_reg[2];

endmodule

// ===== hw/rtl/sts_checker.sv =====
// Port-level checker for the sphere triangle subdivider, bound to the top level.
// Depends on sphere_triangle_subdivider_defines.svh.
`timescale 1ns / 1ps
`include "sphere_triangle_subdivider_defines.svh"

module sts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    // Hold a stalled result beat
    `STS_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    // Never take a triangle while results are pending
    `STS_ASSERT_ALWAYS(a_one_item, !(s_tready && m_tvalid), "input accepted during output")
    // Final child carries no vertex
    `STS_ASSERT_SAME(a_last_novtx, m_tvalid && m_tlast, !m_tuser[0], "last beat flagged vertex")
    // Return to idle after the final beat
    `STS_ASSERT_NEXT(a_idle_after, m_tvalid && m_tready && m_tlast, s_tready, "not ready after last beat")

endmodule

bind sphere_triangle_subdivider sts_checker u_sts_checker (.*);
